// ===== design/lpd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lidar packet decoder: transfer payload types, packet layout constants
// and the sequencer state type. It has no dependencies.
package lpd_pkg;

	localparam int PACKET_BYTES = 22;
	localparam int READINGS = 4;
	localparam int POS_W = 5;
	localparam int RD_IDX_W = 2;

	localparam logic [POS_W-1:0] POS_IDLE = POS_W'(PACKET_BYTES);
	localparam logic [POS_W-1:0] POS_INDEX = 5'd1;
	localparam logic [POS_W-1:0] POS_READ_FIRST = 5'd4;
	localparam logic [POS_W-1:0] POS_CSUM_LO = 5'd20;
	localparam logic [POS_W-1:0] POS_LAST = 5'd21;

	localparam logic [7:0] INDEX_BASE_RESET = 8'd160;
	localparam logic [16:0] RECIP3 = 17'd43691;

	typedef struct packed {
		logic [7:0] byte_value;
		logic packet_start;
	} lpd_in_t;

	typedef struct packed {
		logic [7:0] packet_number;
		logic [1:0] reading_number;
		logic [9:0] angle;
		logic [13:0] distance;
		logic invalid;
		logic strength_warning;
		logic [15:0] strength;
		logic checksum_ok;
		logic [13:0] average_distance;
		logic last;
	} lpd_out_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_READ,
		ST_LOAD
	} lpd_state_t;

endpackage

// ===== design/lidar_packet_decoder.sv =====
`timescale 1ns / 1ps
// Lidar packet decoder: takes one stream byte per transfer and emits four readings per packet.
// Depends on lpd_pkg for payload types, layout constants and the sequencer state type.
// Each reading passes from the reading memory through ST_READ and ST_LOAD (held while the output stalls) to the output.
// Throughput: one byte per cycle while a packet is collected; after its last byte the input
// stalls while the four readings are read from the reading memory, via ST_READ then ST_LOAD each.
// Reset puts the decoder idle awaiting a start byte with index_base at 160.
module lidar_packet_decoder
	import lpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  lpd_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output lpd_out_t out_data,
	input  logic     cfg_we,
	input  logic [7:0] cfg_wdata
);

	lpd_state_t state_q, state_next;
	logic [POS_W-1:0] pos_q, eff_pos, rd_off;
	logic [RD_IDX_W-1:0] rd_idx_q;
	logic [7:0] index_base_q;
	logic [26:0] acc_q;
	logic [15:0] sum_q;
	logic [2:0] cnt_q;
	logic [7:0] low_q, idx_q, rcv_lo_q;
	logic [23:0] asm_q;
	logic ok_q;
	logic [13:0] avg_q;
	logic [31:0] rd_data_q;
	logic out_valid_q;
	lpd_out_t out_data_q;
	logic [31:0] mem [READINGS];

	logic in_accept, active, in_reading, pos_odd, load_out, out_free;
	logic [14:0] csum_calc;
	logic [15:0] csum_rcv;
	logic [32:0] prod3;
	logic [15:0] avg16;
	logic [7:0] angle_diff;

	assign in_accept = in_valid && !in_stall;
	assign eff_pos = in_data.packet_start ? '0 : pos_q;
	assign active = in_accept && (eff_pos < POS_IDLE);
	assign rd_off = eff_pos - POS_READ_FIRST;
	assign in_reading = (eff_pos >= POS_READ_FIRST) && (eff_pos < POS_CSUM_LO);
	assign pos_odd = eff_pos[0];
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign csum_calc = 15'({1'b0, acc_q[14:0]} + 16'(acc_q[26:15]));
	assign csum_rcv = {in_data.byte_value, rcv_lo_q};
	assign prod3 = 33'(sum_q) * 33'(RECIP3);
	assign angle_diff = idx_q - index_base_q;

	always_comb begin
		unique case (cnt_q)
			3'd1: avg16 = sum_q;
			3'd2: avg16 = sum_q >> 1;
			3'd3: avg16 = prod3[32:17];
			3'd4: avg16 = sum_q >> 2;
			default: avg16 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_stall = 1'b0;
				if (active && eff_pos == POS_LAST) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_next = (rd_idx_q == RD_IDX_W'(READINGS - 1)) ? ST_RUN : ST_READ;
				end
			end
			default: begin
				state_next = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			rd_idx_q <= '0;
			index_base_q <= INDEX_BASE_RESET;
			acc_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				index_base_q <= cfg_wdata;
			end
			if (in_accept) begin
				if (in_data.packet_start) begin
					acc_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
				end else if (active) begin
					if (pos_odd && eff_pos < POS_CSUM_LO) begin
						acc_q <= 27'({acc_q, 1'b0} + 28'({in_data.byte_value, low_q}));
					end
					if (in_reading && rd_off[1:0] == 2'd1 && !in_data.byte_value[7]) begin
						sum_q <= sum_q + 16'({in_data.byte_value[5:0], low_q});
						cnt_q <= cnt_q + 3'd1;
					end
				end
				if (active) begin
					pos_q <= (eff_pos == POS_LAST) ? POS_IDLE : eff_pos + 5'd1;
				end
			end
			if (state_q == ST_RUN && state_next == ST_READ) begin
				rd_idx_q <= '0;
			end else if (load_out) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			if (!pos_odd) begin
				low_q <= in_data.byte_value;
			end
			if (eff_pos == POS_INDEX) begin
				idx_q <= in_data.byte_value;
			end
			if (eff_pos == POS_CSUM_LO) begin
				rcv_lo_q <= in_data.byte_value;
			end
			if (eff_pos == POS_LAST) begin
				ok_q <= ({1'b0, csum_calc} == csum_rcv);
			end
			if (in_reading) begin
				case (rd_off[1:0])
					2'd0: asm_q[7:0] <= in_data.byte_value;
					2'd1: asm_q[15:8] <= in_data.byte_value;
					2'd2: asm_q[23:16] <= in_data.byte_value;
					default: mem[rd_off[3:2]] <= {in_data.byte_value, asm_q};
				endcase
			end
		end
		rd_data_q <= mem[rd_idx_q];
		if (state_q == ST_READ) begin
			avg_q <= avg16[13:0];
		end
		if (load_out) begin
			out_data_q.packet_number <= idx_q;
			out_data_q.reading_number <= rd_idx_q;
			out_data_q.angle <= 10'(10'(angle_diff) * 10'(READINGS)) + 10'(rd_idx_q);
			out_data_q.distance <= {rd_data_q[13:8], rd_data_q[7:0]};
			out_data_q.invalid <= rd_data_q[15];
			out_data_q.strength_warning <= rd_data_q[14];
			out_data_q.strength <= rd_data_q[31:16];
			out_data_q.checksum_ok <= ok_q;
			out_data_q.average_distance <= avg_q;
			out_data_q.last <= (rd_idx_q == RD_IDX_W'(READINGS - 1));
		end
	end

endmodule
